@@ design/cams_pkg.sv @@
`timescale 1ns / 1ps

package cams_pkg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [4:0] M_IMM      = 5'd0;
    localparam logic [4:0] M_ZP       = 5'd1;
    localparam logic [4:0] M_ZPX      = 5'd2;
    localparam logic [4:0] M_ZPY      = 5'd3;
    localparam logic [4:0] M_ABS_ADDR = 5'd4;
    localparam logic [4:0] M_ABS      = 5'd5;
    localparam logic [4:0] M_ABSX     = 5'd6;
    localparam logic [4:0] M_ABSY     = 5'd7;
    localparam logic [4:0] M_INDX     = 5'd8;
    localparam logic [4:0] M_INDY     = 5'd9;
    localparam logic [4:0] M_ST_ZP    = 5'd10;
    localparam logic [4:0] M_ST_ABS   = 5'd11;
    localparam logic [4:0] M_ST_ZPX   = 5'd12;
    localparam logic [4:0] M_ST_ZPY   = 5'd13;
    localparam logic [4:0] M_ST_ABSX  = 5'd14;
    localparam logic [4:0] M_ST_ABSY  = 5'd15;
    localparam logic [4:0] M_ST_INDX  = 5'd16;
    localparam logic [4:0] M_ST_INDY  = 5'd17;
    localparam logic [4:0] M_RMW      = 5'd18;

    localparam logic [1:0] K_READ  = 2'd0;
    localparam logic [1:0] K_WRITE = 2'd1;
    localparam logic [1:0] K_DONE  = 2'd2;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_OPER    = 4'd1,
        ST_HIGH    = 4'd2,
        ST_ZPIDX   = 4'd3,
        ST_PTRLO   = 4'd4,
        ST_PTRHI   = 4'd5,
        ST_DATA    = 4'd6,
        ST_REPEAT  = 4'd7,
        ST_DUMMY   = 4'd8,
        ST_PTRBASE = 4'd9
    } t_step;

    typedef struct packed {
        logic       cmd;
        logic [4:0] mode;
        logic [15:0] pc;
        logic [7:0] index_x;
        logic [7:0] index_y;
        logic [7:0] store_data;
        logic       page_check;
        logic [7:0] read_data;
    } t_request;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] bus_address;
        logic [7:0]  bus_write_data;
        logic [15:0] effective_addr;
        logic [7:0]  operand_data;
        logic [15:0] next_pc;
        logic        last;
    } t_result;

endpackage

@@ design/cpu_addressing_mode_sequencer.sv @@
`timescale 1ns / 1ps
// Results are registered into the output queue. Throughput: one request per cycle while
//   each request yields one result and i_ready is high; a request that yields two or
//   three results (stores, read-modify-write) occupies the output queue and holds o_ready
//   low until the queue drains back to at most one entry.
// Reset (synchronous, active low): sequencer idle, all saved state zero, output queue empty,
//   cycle_exact set.

module cpu_addressing_mode_sequencer
    import cams_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_request i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_result,
    input  logic     i_cfg_we,
    input  logic     i_cfg_data
);

    logic        r_cycle_exact;
    t_step       r_step, n_step;
    logic [4:0]  r_mode, n_mode;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_x, n_x;
    logic [7:0]  r_y, n_y;
    logic [7:0]  r_store, n_store;
    logic        r_pgc, n_pgc;
    logic [7:0]  r_low, n_low;
    logic [7:0]  r_high, n_high;
    logic [15:0] r_la, n_la;
    logic [7:0]  r_ldata, n_ldata;

    t_result          r_q [QDepth];
    logic [QAw-1:0]   r_wr_ptr;
    logic [QAw-1:0]   r_rd_ptr;
    logic [QAw:0]     r_count;

    logic        acc;
    logic        pop;
    logic [1:0]  nres;
    logic [1:0]  s_kind [3];
    logic [15:0] s_addr [3];
    logic [7:0]  s_wd   [3];
    t_result     res    [3];
    logic [7:0]  ix;
    logic [7:0]  d;
    logic [15:0] base;

    assign o_ready  = (r_count <= (QAw+1)'(1));
    assign acc      = i_valid && o_ready;
    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && i_ready;
    assign o_result = r_q[r_rd_ptr];
    assign d        = i_req.read_data;
    assign ix       = (r_mode inside {M_ZPY, M_ABSY, M_INDY, M_ST_ZPY, M_ST_ABSY, M_ST_INDY})
                      ? r_y : r_x;

    always_comb begin
        n_step  = r_step;
        n_mode  = r_mode;
        n_pc    = r_pc;
        n_x     = r_x;
        n_y     = r_y;
        n_store = r_store;
        n_pgc   = r_pgc;
        n_low   = r_low;
        n_high  = r_high;
        n_la    = r_la;
        n_ldata = r_ldata;
        nres    = 2'd0;
        base    = '0;
        for (int k = 0; k < 3; k++) begin
            s_kind[k] = K_DONE;
            s_addr[k] = '0;
            s_wd[k]   = '0;
        end
        if (acc) begin
            if (i_req.cmd == CMD_START) begin
                n_mode  = i_req.mode;
                n_pc    = i_req.pc;
                n_x     = i_req.index_x;
                n_y     = i_req.index_y;
                n_store = i_req.store_data;
                n_pgc   = i_req.page_check;
                if (i_req.mode == M_RMW) begin
                    n_step = ST_IDLE;
                    if (r_cycle_exact) begin
                        s_kind[0] = K_WRITE; s_addr[0] = r_la; s_wd[0] = r_ldata;
                        s_kind[1] = K_WRITE; s_addr[1] = r_la; s_wd[1] = i_req.store_data;
                        nres = 2'd3;
                    end else begin
                        s_kind[0] = K_WRITE; s_addr[0] = r_la; s_wd[0] = i_req.store_data;
                        nres = 2'd2;
                    end
                end else if (i_req.mode > M_RMW) begin
                    n_step = ST_IDLE;
                    nres   = 2'd1;
                end else begin
                    n_pc      = i_req.pc + 16'd1;
                    s_kind[0] = K_READ;
                    s_addr[0] = i_req.pc + 16'd1;
                    n_step    = ST_OPER;
                    nres      = 2'd1;
                end
            end else begin
                case (r_step)
                    ST_OPER: begin
                        n_ldata = d;
                        n_low   = d;
                        nres    = 2'd1;
                        s_kind[0] = K_READ;
                        case (r_mode)
                            M_IMM: begin
                                s_kind[0] = K_DONE;
                                n_step = ST_IDLE;
                            end
                            M_ZP: begin
                                n_la = {8'h00, d};
                                s_addr[0] = {8'h00, d};
                                n_step = ST_DATA;
                            end
                            M_ZPX, M_ZPY: begin
                                if (r_cycle_exact) begin
                                    s_addr[0] = r_pc + 16'd1;
                                    n_step = ST_ZPIDX;
                                end else begin
                                    n_la = {8'h00, 8'(d + ix)};
                                    s_addr[0] = {8'h00, 8'(d + ix)};
                                    n_step = ST_DATA;
                                end
                            end
                            M_INDX: begin
                                n_low = 8'(d + ix);
                                s_addr[0] = {8'h00, 8'(d + ix)};
                                n_step = ST_PTRBASE;
                            end
                            M_ST_INDX: begin
                                n_low = 8'(d + ix);
                                s_addr[0] = {8'h00, d};
                                n_step = ST_PTRBASE;
                            end
                            M_INDY, M_ST_INDY: begin
                                s_addr[0] = {8'h00, d};
                                n_step = ST_PTRLO;
                            end
                            M_ST_ZP: begin
                                n_la = {8'h00, d};
                                s_kind[0] = K_WRITE; s_addr[0] = {8'h00, d}; s_wd[0] = r_store;
                                n_step = ST_IDLE;
                                nres = 2'd2;
                            end
                            M_ST_ZPX, M_ST_ZPY: begin
                                n_la = {8'h00, 8'(d + ix)};
                                if (r_cycle_exact) begin
                                    s_addr[0] = {8'h00, d};
                                    n_step = ST_DUMMY;
                                end else begin
                                    s_kind[0] = K_WRITE;
                                    s_addr[0] = {8'h00, 8'(d + ix)};
                                    s_wd[0]   = r_store;
                                    n_step = ST_IDLE;
                                    nres = 2'd2;
                                end
                            end
                            default: begin
                                n_pc = r_pc + 16'd1;
                                s_addr[0] = r_pc + 16'd1;
                                n_step = ST_HIGH;
                            end
                        endcase
                    end
                    ST_HIGH: begin
                        n_ldata = d;
                        n_high  = d;
                        base    = {d, r_low};
                        nres    = 2'd1;
                        s_kind[0] = K_READ;
                        case (r_mode)
                            M_ABS_ADDR: begin
                                n_la = base;
                                s_kind[0] = K_DONE;
                                n_step = ST_IDLE;
                            end
                            M_ABS: begin
                                n_la = base;
                                s_addr[0] = base;
                                n_step = ST_DATA;
                            end
                            M_ABSX, M_ABSY: begin
                                n_la = base + {8'h00, ix};
                                s_addr[0] = base + {8'h00, ix};
                                n_step = ST_DATA;
                            end
                            M_ST_ABS: begin
                                n_la = base;
                                s_kind[0] = K_WRITE; s_addr[0] = base; s_wd[0] = r_store;
                                n_step = ST_IDLE;
                                nres = 2'd2;
                            end
                            default: begin
                                n_la = base + {8'h00, ix};
                                s_addr[0] = base + {8'h00, ix};
                                if (r_cycle_exact) begin
                                    n_step = ST_DUMMY;
                                end else begin
                                    s_kind[0] = K_WRITE; s_wd[0] = r_store;
                                    n_step = ST_IDLE;
                                    nres = 2'd2;
                                end
                            end
                        endcase
                    end
                    ST_ZPIDX: begin
                        n_la = {8'h00, 8'(r_low + ix)};
                        s_kind[0] = K_READ; s_addr[0] = {8'h00, 8'(r_low + ix)};
                        n_step = ST_DATA;
                        nres = 2'd1;
                    end
                    ST_PTRBASE: begin
                        s_kind[0] = K_READ; s_addr[0] = {8'h00, r_low};
                        n_step = ST_PTRLO;
                        nres = 2'd1;
                    end
                    ST_PTRLO: begin
                        n_high = d;
                        s_kind[0] = K_READ; s_addr[0] = {8'h00, 8'(r_low + 8'd1)};
                        n_step = ST_PTRHI;
                        nres = 2'd1;
                    end
                    ST_PTRHI: begin
                        n_low  = r_high;
                        n_high = d;
                        base   = {d, r_high};
                        nres   = 2'd1;
                        s_kind[0] = K_READ;
                        if (r_mode == M_INDX || r_mode == M_ST_INDX) begin
                            n_la = base;
                            s_addr[0] = base;
                            if (r_mode == M_INDX) begin
                                n_step = ST_DATA;
                            end else begin
                                s_kind[0] = K_WRITE; s_wd[0] = r_store;
                                n_step = ST_IDLE;
                                nres = 2'd2;
                            end
                        end else begin
                            n_la = base + {8'h00, ix};
                            s_addr[0] = base + {8'h00, ix};
                            if (r_mode == M_INDY) begin
                                n_step = ST_DATA;
                            end else if (r_cycle_exact) begin
                                n_step = ST_DUMMY;
                            end else begin
                                s_kind[0] = K_WRITE; s_wd[0] = r_store;
                                n_step = ST_IDLE;
                                nres = 2'd2;
                            end
                        end
                    end
                    ST_DATA: begin
                        n_ldata = d;
                        nres = 2'd1;
                        if ((r_mode == M_ABSX || r_mode == M_ABSY || r_mode == M_INDY) &&
                            r_cycle_exact && r_pgc && (r_la[15:8] != r_high)) begin
                            s_kind[0] = K_READ; s_addr[0] = r_la;
                            n_step = ST_REPEAT;
                        end else begin
                            n_step = ST_IDLE;
                        end
                    end
                    ST_REPEAT: begin
                        n_ldata = d;
                        n_step = ST_IDLE;
                        nres = 2'd1;
                    end
                    ST_DUMMY: begin
                        s_kind[0] = K_WRITE; s_addr[0] = r_la; s_wd[0] = r_store;
                        n_step = ST_IDLE;
                        nres = 2'd2;
                    end
                    default: begin
                        n_step = ST_IDLE;
                    end
                endcase
            end
        end
        for (int k = 0; k < 3; k++) begin
            res[k].kind           = s_kind[k];
            res[k].bus_address    = (s_kind[k] == K_DONE) ? 16'h0000 : s_addr[k];
            res[k].bus_write_data = (s_kind[k] == K_WRITE) ? s_wd[k] : 8'h00;
            res[k].effective_addr = (s_kind[k] == K_DONE) ? n_la : 16'h0000;
            res[k].operand_data   = (s_kind[k] == K_DONE) ? n_ldata : 8'h00;
            res[k].next_pc        = (s_kind[k] == K_DONE) ? n_pc : 16'h0000;
            res[k].last           = (k == int'(nres) - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_exact <= 1'b1;
            r_step   <= ST_IDLE;
            r_mode   <= '0;
            r_pc     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_store  <= '0;
            r_pgc    <= 1'b0;
            r_low    <= '0;
            r_high   <= '0;
            r_la     <= '0;
            r_ldata  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cycle_exact <= i_cfg_data;
            end
            r_step   <= n_step;
            r_mode   <= n_mode;
            r_pc     <= n_pc;
            r_x      <= n_x;
            r_y      <= n_y;
            r_store  <= n_store;
            r_pgc    <= n_pgc;
            r_low    <= n_low;
            r_high   <= n_high;
            r_la     <= n_la;
            r_ldata  <= n_ldata;
            r_wr_ptr <= r_wr_ptr + QAw'(nres);
            r_rd_ptr <= r_rd_ptr + QAw'(pop);
            r_count  <= r_count + (QAw+1)'(nres) - (QAw+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (k < int'(nres)) begin
                r_q[r_wr_ptr + QAw'(k)] <= res[k];
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAw+1)'(QDepth))
        else $error("output queue overfilled");

    a_start_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_req.cmd == CMD_START && i_req.mode < M_RMW |=> r_step == ST_OPER)
        else $error("start did not enter operand fetch");

    a_idle_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_req.cmd == CMD_DATA && r_step == ST_IDLE |=> r_step == ST_IDLE)
        else $error("stray read data left idle");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !acc |=> r_count == $past(r_count) - (QAw+1)'(1))
        else $error("queue count did not drop on pop");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.kind == K_DONE |-> o_result.last)
        else $error("done result not marked last");

endmodule
